### rtl/core/icy_pkg.sv
// ----------------------------------------------------------------------------
// icy_pkg
// Types and constants for the stream metadata demux and title extractor.
// ----------------------------------------------------------------------------
package icy_pkg;

  // stream phase within one audio/metadata block
  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_META  = 2'd2
  } phase_t;

  // title matcher phase
  typedef enum logic [1:0] {
    TP_SEARCH = 2'd0,
    TP_TITLE  = 2'd1,
    TP_FOUND  = 2'd2,
    TP_STOP   = 2'd3
  } title_phase_t;

  // classification of a stream byte
  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_LEN   = 2'd1;
  localparam logic [1:0] KIND_META  = 2'd2;

  localparam int unsigned META_CNT_WIDTH = 12;
  localparam int unsigned LEN_SHIFT      = 4;   // length byte counts 16-byte units
  localparam int unsigned KEY_LEN        = 13;
  localparam int unsigned KEY_IDX_WIDTH  = 4;
  localparam int unsigned CFG_MAX_WIDTH  = 16;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_S     = 8'h53;

  localparam logic [KEY_IDX_WIDTH-1:0] KEY_LAST = KEY_IDX_WIDTH'(KEY_LEN - 1);

  // StreamTitle='
  function automatic logic [7:0] key_char(input logic [KEY_IDX_WIDTH-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h53;  // S
      4'd1:    ch = 8'h74;  // t
      4'd2:    ch = 8'h72;  // r
      4'd3:    ch = 8'h65;  // e
      4'd4:    ch = 8'h61;  // a
      4'd5:    ch = 8'h6d;  // m
      4'd6:    ch = 8'h54;  // T
      4'd7:    ch = 8'h69;  // i
      4'd8:    ch = 8'h74;  // t
      4'd9:    ch = 8'h6c;  // l
      4'd10:   ch = 8'h65;  // e
      4'd11:   ch = 8'h3d;  // =
      4'd12:   ch = 8'h27;  // '
      default: ch = 8'h53;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/icy_metadata_demux_title_extract_top.sv
// ----------------------------------------------------------------------------
// icy_metadata_demux_title_extract_top
// Splits a received byte stream into audio and inline metadata, and pulls the
// stream title out of each metadata block.
// ----------------------------------------------------------------------------
// usage
//   s_* : one raw stream byte per beat (s_tdata[7:0])
//   m_* : one result beat per input beat; tuser carries the byte kind and the
//         title-character flag, tlast marks the byte that ends a metadata block
//   apb : register 0 at address 0 holds the audio chunk length; zero passes
//         every byte through as audio. write it only while the block is idle
// latency: a result appears one cycle after its input beat is accepted
// throughput: one byte per cycle; the counters and the title matcher update
//   in the same cycle as the output register load
// reset: phase returns to audio, all counters and the matcher clear, the chunk
//   length register reads zero, no result is pending
// stall: the output register holds its beat while m_tready is low; s_tready
//   follows, so a new byte is taken in the same cycle the held beat leaves
module icy_metadata_demux_title_extract_top
  import icy_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH  = 48,
  parameter int unsigned CHUNK_LEN_WIDTH = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  // apb register port
  input  logic                                            psel,
  input  logic                                            penable,
  input  logic                                            pwrite,
  input  logic [2:0]                                      paddr,
  input  logic [31:0]                                     pwdata,
  output logic [31:0]                                     prdata,
  output logic                                            pready,
  // stream input
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  input  logic [7:0]                                      s_tdata,  // data_byte
  // stream output
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // audio_byte, audio_position, title_char, title_found, zero fill
  output logic [((POSITION_WIDTH+17+7)/8)*8-1:0]          m_tdata,
  output logic [2:0]                                      m_tuser,  // byte_kind, title_char_valid
  output logic                                            m_tlast   // block_end
);

  localparam int unsigned CFG_WIDTH =
    (CHUNK_LEN_WIDTH < CFG_MAX_WIDTH) ? CHUNK_LEN_WIDTH : CFG_MAX_WIDTH;
  localparam int unsigned TDATA_WIDTH = ((POSITION_WIDTH + 17 + 7) / 8) * 8;
  localparam int unsigned PAD_WIDTH   = TDATA_WIDTH - POSITION_WIDTH - 17;

  // configuration
  logic [CFG_WIDTH-1:0] chunk_len;
  logic                 cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == 1'b0);
  assign prdata  = cfg_sel ? 32'(chunk_len) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_len <= '0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      chunk_len <= pwdata[CFG_WIDTH-1:0];
    end
  end

  // state
  phase_t                         phase, phase_next;
  logic [CHUNK_LEN_WIDTH-1:0]     audio_count, audio_count_next;
  logic [META_CNT_WIDTH-1:0]      meta_remaining, meta_remaining_next;
  logic [KEY_IDX_WIDTH-1:0]       prefix_index, prefix_index_next;
  title_phase_t                   title_phase, title_phase_next;
  logic                           held_quote, held_quote_next;
  logic                           held_valid, held_valid_next;
  logic [7:0]                     held_char, held_char_next;
  logic                           title_nonempty, title_nonempty_next;
  logic [POSITION_WIDTH-1:0]      audio_total, audio_total_next;

  // result of the current byte
  logic [1:0]                     kind_c;
  logic [7:0]                     abyte_c;
  logic                           tvalid_c;
  logic [7:0]                     tchar_c;
  logic                           bend_c;
  logic                           found_c;

  logic                           accept;
  logic [7:0]                     c;
  logic [CHUNK_LEN_WIDTH:0]       count_inc;
  logic [META_CNT_WIDTH-1:0]      meta_dec;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign c         = s_tdata;
  assign count_inc = {1'b0, audio_count} + 1'b1;
  assign meta_dec  = meta_remaining - 1'b1;

  // matcher outputs after one content byte
  title_phase_t             mt_phase;
  logic [KEY_IDX_WIDTH-1:0] mt_index;
  logic                     mt_quote;
  logic                     mt_valid;
  logic [7:0]               mt_char;
  logic                     mt_nonempty;
  logic                     mt_tvalid;
  logic [7:0]               mt_tchar;

  always_comb begin
    mt_phase    = title_phase;
    mt_index    = prefix_index;
    mt_quote    = held_quote;
    mt_valid    = held_valid;
    mt_char     = held_char;
    mt_nonempty = title_nonempty;
    mt_tvalid   = 1'b0;
    mt_tchar    = 8'd0;
    unique case (title_phase)
      TP_SEARCH: begin
        if (c == CHAR_NUL) begin
          mt_phase = TP_STOP;
        end else if (c == key_char(prefix_index)) begin
          if (prefix_index == KEY_LAST) begin
            mt_index = '0;
            mt_phase = TP_TITLE;
          end else begin
            mt_index = prefix_index + 1'b1;
          end
        end else begin
          mt_index = (c == CHAR_S) ? KEY_IDX_WIDTH'(1) : '0;
        end
      end
      TP_TITLE: begin
        // held quote then semicolon closes a non-empty title
        if (held_valid && held_quote && c == CHAR_SEMI && title_nonempty) begin
          mt_phase = TP_FOUND;
          mt_valid = 1'b0;
          mt_quote = 1'b0;
          mt_char  = 8'd0;
        end else begin
          if (held_valid) begin
            mt_tvalid   = 1'b1;
            mt_tchar    = held_char;
            mt_nonempty = 1'b1;
          end
          if (c == CHAR_NUL) begin
            mt_phase = TP_STOP;
            mt_valid = 1'b0;
            mt_quote = 1'b0;
            mt_char  = 8'd0;
          end else begin
            mt_valid = 1'b1;
            mt_char  = c;
            mt_quote = (c == CHAR_QUOTE);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_next          = phase;
    audio_count_next    = audio_count;
    meta_remaining_next = meta_remaining;
    prefix_index_next   = prefix_index;
    title_phase_next    = title_phase;
    held_quote_next     = held_quote;
    held_valid_next     = held_valid;
    held_char_next      = held_char;
    title_nonempty_next = title_nonempty;
    audio_total_next    = audio_total;
    kind_c              = KIND_AUDIO;
    abyte_c             = 8'd0;
    tvalid_c            = 1'b0;
    tchar_c             = 8'd0;
    bend_c              = 1'b0;
    found_c             = 1'b0;

    if (chunk_len == '0) begin
      // pass-through: everything is audio and the block logic stays cleared
      abyte_c             = c;
      audio_total_next    = audio_total + 1'b1;
      phase_next          = PH_AUDIO;
      audio_count_next    = '0;
      meta_remaining_next = '0;
      prefix_index_next   = '0;
      title_phase_next    = TP_SEARCH;
      held_quote_next     = 1'b0;
      held_valid_next     = 1'b0;
      held_char_next      = 8'd0;
      title_nonempty_next = 1'b0;
    end else begin
      unique case (phase)
        PH_LEN: begin
          kind_c              = KIND_LEN;
          prefix_index_next   = '0;
          title_phase_next    = TP_SEARCH;
          held_quote_next     = 1'b0;
          held_valid_next     = 1'b0;
          held_char_next      = 8'd0;
          title_nonempty_next = 1'b0;
          meta_remaining_next = META_CNT_WIDTH'({c, {LEN_SHIFT{1'b0}}});
          if (c == CHAR_NUL) begin
            bend_c     = 1'b1;
            phase_next = PH_AUDIO;
          end else begin
            phase_next = PH_META;
          end
        end
        PH_META: begin
          kind_c              = KIND_META;
          tvalid_c            = mt_tvalid;
          tchar_c             = mt_tchar;
          meta_remaining_next = meta_dec;
          if (meta_dec == '0) begin
            // end of block: any held byte is dropped
            bend_c              = 1'b1;
            found_c             = (mt_phase == TP_FOUND);
            phase_next          = PH_AUDIO;
            prefix_index_next   = '0;
            title_phase_next    = TP_SEARCH;
            held_quote_next     = 1'b0;
            held_valid_next     = 1'b0;
            held_char_next      = 8'd0;
            title_nonempty_next = 1'b0;
          end else begin
            prefix_index_next   = mt_index;
            title_phase_next    = mt_phase;
            held_quote_next     = mt_quote;
            held_valid_next     = mt_valid;
            held_char_next      = mt_char;
            title_nonempty_next = mt_nonempty;
          end
        end
        default: begin
          abyte_c          = c;
          audio_total_next = audio_total + 1'b1;
          // also ends the chunk when the length was lowered below the count
          if (count_inc >= (CHUNK_LEN_WIDTH+1)'(chunk_len)) begin
            phase_next       = PH_LEN;
            audio_count_next = '0;
          end else begin
            phase_next       = PH_AUDIO;
            audio_count_next = count_inc[CHUNK_LEN_WIDTH-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_AUDIO;
      audio_count    <= '0;
      meta_remaining <= '0;
      prefix_index   <= '0;
      title_phase    <= TP_SEARCH;
      held_quote     <= 1'b0;
      held_valid     <= 1'b0;
      held_char      <= 8'd0;
      title_nonempty <= 1'b0;
      audio_total    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      audio_count    <= audio_count_next;
      meta_remaining <= meta_remaining_next;
      prefix_index   <= prefix_index_next;
      title_phase    <= title_phase_next;
      held_quote     <= held_quote_next;
      held_valid     <= held_valid_next;
      held_char      <= held_char_next;
      title_nonempty <= title_nonempty_next;
      audio_total    <= audio_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{PAD_WIDTH{1'b0}}, found_c, tchar_c, audio_total, abyte_c};
      m_tuser <= {tvalid_c, kind_c};
      m_tlast <= bend_c;
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for icy_metadata_demux_title_extract_top. A byte-accurate copy of
// the demux and title matcher runs beside the block. Every result beat is
// checked field by field against it, in order. The stimulus starts with a
// short directed run. It then steps through several chunk lengths, using
// mostly well-formed metadata blocks with random titles and some noise.
// Stalls on both sides are random, but for two chunk lengths that run without them.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icy_pkg::*;

  localparam int unsigned TDATA_W        = ((48 + 17 + 7) / 8) * 8;
  localparam logic [2:0]  REG_CHUNK_LEN  = 3'd0;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES    = 110;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  abyte;
    logic [47:0] pos;
    logic        tvalid;
    logic [7:0]  tchar;
    logic        bend;
    logic        found;
  } demux_beat_t;

  // expected beats from a bit-level copy of the demux and title matcher
  class stream_title_checker;
    localparam logic [8*13-1:0] TITLE_KEY = "StreamTitle='";

    logic [15:0]  chunk_len;
    phase_t       stream_phase;
    logic [15:0]  audio_count;
    logic [11:0]  meta_left;
    logic [3:0]   key_idx;
    title_phase_t tphase;
    bit           held_valid;
    bit           held_quote;
    bit           title_nonempty;
    logic [7:0]   held_char;
    logic [47:0]  audio_total;

    demux_beat_t pending_beats[$];
    int unsigned n_bytes, n_checked, n_errors, n_blocks, n_titles, n_title_chars;

    function new();
      chunk_len    = '0;
      stream_phase = PH_AUDIO;
      audio_count  = '0;
      meta_left    = '0;
      audio_total  = '0;
      clear_matcher();
    endfunction

    function logic [7:0] key_at(input int unsigned idx);
      return TITLE_KEY[8*(12-idx) +: 8];
    endfunction

    function void clear_matcher();
      key_idx        = '0;
      tphase         = TP_SEARCH;
      held_valid     = 1'b0;
      held_quote     = 1'b0;
      held_char      = '0;
      title_nonempty = 1'b0;
    endfunction

    function void scan_title(input logic [7:0] c, inout demux_beat_t e);
      if (tphase == TP_SEARCH) begin
        if (c == CHAR_NUL) begin
          tphase = TP_STOP;
        end else if (c == key_at(key_idx)) begin
          if (key_idx == KEY_LEN - 1) begin
            key_idx = '0;
            tphase  = TP_TITLE;
          end else begin
            key_idx++;
          end
        end else begin
          // a stray S can start the key over
          key_idx = (c == CHAR_S) ? 4'd1 : 4'd0;
        end
      end else if (tphase == TP_TITLE) begin
        if (held_valid && held_quote && c == CHAR_SEMI && title_nonempty) begin
          tphase     = TP_FOUND;
          held_valid = 1'b0;
          held_quote = 1'b0;
          held_char  = '0;
        end else begin
          if (held_valid) begin
            e.tvalid       = 1'b1;
            e.tchar        = held_char;
            title_nonempty = 1'b1;
          end
          if (c == CHAR_NUL) begin
            tphase     = TP_STOP;
            held_valid = 1'b0;
            held_quote = 1'b0;
            held_char  = '0;
          end else begin
            held_valid = 1'b1;
            held_char  = c;
            held_quote = (c == CHAR_QUOTE);
          end
        end
      end
    endfunction

    function void note_byte(input logic [7:0] c);
      demux_beat_t e;
      e     = '0;
      e.pos = audio_total;
      n_bytes++;
      if (chunk_len == 0) begin
        e.kind       = KIND_AUDIO;
        e.abyte      = c;
        audio_total++;
        stream_phase = PH_AUDIO;
        audio_count  = '0;
        meta_left    = '0;
        clear_matcher();
      end else if (stream_phase == PH_LEN) begin
        e.kind = KIND_LEN;
        clear_matcher();
        meta_left = {c, 4'b0000};
        if (c == 8'd0) begin
          e.bend       = 1'b1;
          stream_phase = PH_AUDIO;
        end else begin
          stream_phase = PH_META;
        end
      end else if (stream_phase == PH_META) begin
        e.kind = KIND_META;
        scan_title(c, e);
        meta_left--;
        if (meta_left == 0) begin
          e.bend       = 1'b1;
          e.found      = (tphase == TP_FOUND);
          stream_phase = PH_AUDIO;
          clear_matcher();
        end
      end else begin
        e.kind  = KIND_AUDIO;
        e.abyte = c;
        audio_total++;
        // a chunk length lowered below the count ends the audio part at once
        if ({1'b0, audio_count} + 17'd1 >= {1'b0, chunk_len}) begin
          stream_phase = PH_LEN;
          audio_count  = '0;
        end else begin
          audio_count++;
        end
      end
      n_blocks      += e.bend;
      n_titles      += e.found;
      n_title_chars += e.tvalid;
      pending_beats.push_back(e);
    endfunction

    task report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
      n_errors++;
      if (n_errors <= 30)
        $display("beat %0d: %s is %0h, should be %0h", n_checked, field, got, want);
    endtask

    task check_beat(input demux_beat_t got);
      demux_beat_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing outstanding", 64'(got.pos), 64'd0);
        return;
      end
      want = pending_beats.pop_front();
      n_checked++;
      if (got.kind !== want.kind)
        report_mismatch("byte_kind", 64'(got.kind), 64'(want.kind));
      if (got.abyte !== want.abyte)
        report_mismatch("audio_byte", 64'(got.abyte), 64'(want.abyte));
      if (got.pos !== want.pos)
        report_mismatch("audio_position", 64'(got.pos), 64'(want.pos));
      if (got.tvalid !== want.tvalid)
        report_mismatch("title_char_valid", 64'(got.tvalid), 64'(want.tvalid));
      if (got.tchar !== want.tchar)
        report_mismatch("title_char", 64'(got.tchar), 64'(want.tchar));
      if (got.bend !== want.bend)
        report_mismatch("block_end", 64'(got.bend), 64'(want.bend));
      if (got.found !== want.found)
        report_mismatch("title_found", 64'(got.found), 64'(want.found));
    endtask
  endclass

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [2:0]         paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;   // audio_byte, audio_position, title_char, title_found, zero fill
  logic [2:0]         m_tuser;   // byte_kind, title_char_valid
  logic               m_tlast;   // block_end

  stream_title_checker sb;
  logic [7:0]          byte_q[$];
  bit                  idle_on  = 1'b1;
  bit                  hold_req = 1'b0;
  int unsigned         gap_left, stall_left, quiet;
  demux_beat_t         out_beat;

  always #5 clk = ~clk;

  icy_metadata_demux_title_extract_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always_comb begin
    out_beat.abyte  = m_tdata[7:0];
    out_beat.pos    = m_tdata[55:8];
    out_beat.tchar  = m_tdata[63:56];
    out_beat.found  = m_tdata[64];
    out_beat.kind   = m_tuser[1:0];
    out_beat.tvalid = m_tuser[2];
    out_beat.bend   = m_tlast;
  end

  // sender: one stream byte per beat, random gap bursts after a beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= byte_q.pop_front();
        if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 14);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(out_beat);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("no beat for %0d cycles", quiet);
        $display("icy_metadata_demux_title_extract_top: mismatch");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (byte_q.size() != 0 || s_tvalid || sb.pending_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_chunk_len(input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CHUNK_LEN;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.chunk_len = value;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // one audio chunk, a length byte and a metadata block, mostly holding a title
  task automatic push_block(input int unsigned n_audio, input bit max_len,
                            output int unsigned count);
    logic [7:0]  meta[$];
    int unsigned variant, i, n, lead, units, need;
    bit          fill;
    variant = $urandom_range(0, 9);
    if (variant < 2) begin
      repeat (16 * $urandom_range(1, 2)) meta.push_back(8'($urandom_range(0, 255)));
    end else begin
      lead = max_len ? $urandom_range(0, 3900) : $urandom_range(0, 4);
      repeat (lead) meta.push_back(8'($urandom_range(32, 126)));
      if (variant == 2) begin
        // key cut short, then the real one
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) meta.push_back(sb.key_at(i));
      end
      for (i = 0; i < KEY_LEN; i++) meta.push_back(sb.key_at(i));
      if (variant == 5) begin
        n = meta.size() - $urandom_range(1, KEY_LEN);
        meta[n] = meta[n] ^ 8'h20;
      end
      if (variant == 3) repeat ($urandom_range(1, 3)) meta.push_back(CHAR_QUOTE);
      n = $urandom_range((variant == 3) ? 0 : 1, 20);
      for (i = 0; i < n; i++)
        meta.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(32, 126)));
      if (variant == 4) meta.push_back(CHAR_NUL);
      meta.push_back(CHAR_QUOTE);
      meta.push_back(CHAR_SEMI);
      repeat ($urandom_range(0, 8)) meta.push_back(8'($urandom_range(0, 255)));
    end
    need = (meta.size() + 15) / 16;
    if (max_len) begin
      units = 255;
    end else begin
      case ($urandom_range(0, 9))
        0:       units = 0;
        1:       units = need - 1;
        2:       units = need + 1;
        default: units = need;
      endcase
    end
    while (meta.size() > units * 16) void'(meta.pop_back());
    fill = $urandom_range(0, 1);
    while (meta.size() < units * 16)
      meta.push_back(fill ? 8'($urandom_range(0, 255)) : CHAR_NUL);
    push_random(n_audio);
    byte_q.push_back(8'(units));
    foreach (meta[k]) byte_q.push_back(meta[k]);
    count = n_audio + 1 + units * 16;
  endtask

  initial begin
    logic [15:0] chunk_plan [8];
    int unsigned i, pushed, blk_bytes;
    chunk_plan = '{16'd3, 16'd1, 16'd0, 16'd24, 16'd2, 16'd200, 16'd5, 16'd1};
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // chunk length zero: every byte is audio
    @(negedge clk);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hff);
    wait_idle();
    write_chunk_len(16'hffff);
    @(negedge clk);
    byte_q.push_back(8'h55);
    byte_q.push_back(8'haa);
    byte_q.push_back(8'h0f);
    wait_idle();
    // lowered below the bytes already counted: one more audio byte, then length
    write_chunk_len(16'd1);
    @(negedge clk);
    byte_q.push_back(8'hf0);
    byte_q.push_back(8'h00);   // empty block
    byte_q.push_back(8'h53);
    byte_q.push_back(8'h01);
    // empty title: the quote becomes a title byte, NUL stops the scan
    for (i = 0; i < KEY_LEN; i++) byte_q.push_back(sb.key_at(i));
    byte_q.push_back(CHAR_QUOTE);
    byte_q.push_back(CHAR_SEMI);
    byte_q.push_back(CHAR_NUL);

    foreach (chunk_plan[p]) begin
      // sender holds back here until every result is in
      wait_idle();
      idle_on = (p != 3) && (p != 7);
      write_chunk_len(chunk_plan[p]);
      @(negedge clk);
      // finish whatever block the previous phase cut off
      if (chunk_plan[p] != 0) begin
        if (sb.stream_phase == PH_META) begin
          push_random(32'(sb.meta_left));
        end else if (sb.stream_phase == PH_LEN) begin
          byte_q.push_back(8'h00);
        end else if (sb.audio_count != 0) begin
          push_random((chunk_plan[p] > sb.audio_count) ? chunk_plan[p] - sb.audio_count : 1);
          byte_q.push_back(8'h00);
        end
      end
      if (chunk_plan[p] == 0) begin
        push_random(PHASE_BYTES);
      end else begin
        pushed = 0;
        while (pushed < PHASE_BYTES) begin
          push_block(chunk_plan[p], 1'b0, blk_bytes);
          pushed += blk_bytes;
        end
        if (p != 7 && $urandom_range(0, 1) == 1)
          repeat ($urandom_range(1, blk_bytes - 1)) void'(byte_q.pop_back());
      end
      if (p == 1) hold_req = 1'b1;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("%0d bytes over %0d chunk lengths, %0d beats compared", sb.n_bytes,
             $size(chunk_plan) + 3, sb.n_checked);
    $display("%0d metadata blocks closed, %0d with a title, %0d title bytes",
             sb.n_blocks, sb.n_titles, sb.n_title_chars);
    if (sb.n_errors == 0 && sb.pending_beats.size() == 0) begin
      $display("icy_metadata_demux_title_extract_top: match");
    end else begin
      $display("icy_metadata_demux_title_extract_top: mismatch");
    end
    $finish;
  end

endmodule
